FILE: design/tli_pkg.sv
// Shared types and constants of the table linear interpolator.
// Item, result and search packet layouts; used by tli_cell and table_linear_interpolator.
package tli_pkg;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// quotient bits produced by the divider (quotient stays below 2^33)
	localparam int DIV_STEPS = 33;

	typedef logic [6:0] count_t;

	typedef struct packed {
		logic               opcode;
		logic [5:0]         point_index;
		logic [31:0]        point_lambda;
		logic signed [31:0] point_flux;
		logic [31:0]        query_lambda;
	} item_t;

	typedef struct packed {
		logic signed [31:0] flux_value;
		logic               clamped_low;
		logic               clamped_high;
	} result_t;

	// search word handed from cell to cell
	typedef struct packed {
		logic [31:0] q;
		logic [31:0] prev_l;
		logic [31:0] prev_f;
		logic [31:0] first_l;
		logic [31:0] first_f;
		logic [31:0] last_l;
		logic [31:0] last_f;
		logic        found;
		logic [31:0] l0;
		logic [31:0] f0;
		logic [31:0] l1;
		logic [31:0] f1;
	} pkt_t;

endpackage

FILE: design/tli_chan_if.sv
// Valid/ready channel carrying one word of a given payload type.
// Depends on nothing; payload types come from tli_pkg at instantiation.
interface tli_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: design/tli_cell.sv
// One table point of the interpolator chain: stores a point and examines the
// passing search word against it. Depends on tli_pkg.
module tli_cell #(
	parameter int IDX = 0,
	parameter int NW  = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [5:0]    wr_index,
	input  logic [31:0]   wr_lambda,
	input  logic [31:0]   wr_flux,
	input  logic [NW-1:0] n_eff,
	input  logic          vld_in,
	input  tli_pkg::pkt_t pkt_in,
	output logic          vld_out,
	output tli_pkg::pkt_t pkt_out
);
	import tli_pkg::*;

	logic [31:0] lambda_q;
	logic [31:0] flux_q;
	pkt_t        nxt;

	// hold the point written by a load
	always_ff @(posedge clk) begin
		if (wr_en && (32'(wr_index) == IDX)) begin
			lambda_q <= wr_lambda;
			flux_q   <= wr_flux;
		end
	end

	// examine the word against this point
	always_comb begin
		nxt = pkt_in;
		if (IDX == 0) begin
			nxt.first_l = lambda_q;
			nxt.first_f = flux_q;
		end
		if ((IDX >= 1) && (n_eff > NW'(IDX)) && !pkt_in.found &&
				(pkt_in.prev_l <= pkt_in.q) && (pkt_in.q < lambda_q)) begin
			nxt.found = 1'b1;
			nxt.l0    = pkt_in.prev_l;
			nxt.f0    = pkt_in.prev_f;
			nxt.l1    = lambda_q;
			nxt.f1    = flux_q;
		end
		if (n_eff == NW'(IDX + 1)) begin
			nxt.last_l = lambda_q;
			nxt.last_f = flux_q;
		end
		nxt.prev_l = lambda_q;
		nxt.prev_f = flux_q;
	end

	// advance the word to the neighbor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		pkt_out <= nxt;
	end

endmodule

FILE: design/table_linear_interpolator.sv
// Piecewise linear interpolation over a table of TABLE_DEPTH points.
// Load: accepted when idle, gives no result. Query: when interpolated, the result passes
// the chain stages, the decide step, the multiply and add steps, 33 divide steps and the
// output register; when clamped it skips multiply and divide. One item in flight at a time.
// Reset clears control and sets point_count to 1; table contents stay undefined.
module table_linear_interpolator #(
	parameter int TABLE_DEPTH = 64
) (
	input logic         clk,
	input logic         arst_n,
	tli_chan_if.sink    item,
	tli_chan_if.source  result,
	tli_chan_if.sink    cfg
);
	import tli_pkg::*;

	localparam int NW = $clog2(TABLE_DEPTH + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SRCH = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_ADD  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0]           state_q;
	count_t               count_q;
	logic [NW-1:0]        n_eff;
	logic                 acc, load_en, launch;
	logic [TABLE_DEPTH:0] chain_vld;
	pkt_t                 chain_pkt [TABLE_DEPTH+1];
	pkt_t                 launch_pkt;
	pkt_t                 tail;

	logic [31:0] f0_q, t_q, span_q, res_flux_q;
	logic [32:0] mag_q, d;
	logic        neg_q, interp_q, lo_q, hi_q;
	logic [63:0] prod_s1;
	logic [64:0] dvd;
	logic [31:0] rem_q;
	logic [32:0] quo_q, trial;
	logic        ge;
	logic [5:0]  cnt_q;
	logic [31:0] fin_flux;
	logic        out_valid_q, out_load;
	result_t     out_q;

	// accept config always, items only when idle
	assign cfg.ready  = 1'b1;
	assign item.ready = (state_q == ST_IDLE);
	assign acc        = item.valid && item.ready;
	assign load_en    = acc && (item.data.opcode == OP_LOAD);
	assign launch     = acc && (item.data.opcode == OP_QUERY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= count_t'(1);
		end else if (cfg.valid) begin
			count_q <= cfg.data;
		end
	end

	// clamp point count into 1..TABLE_DEPTH
	always_comb begin
		if (count_q == '0) begin
			n_eff = NW'(1);
		end else if (32'(count_q) > TABLE_DEPTH) begin
			n_eff = NW'(TABLE_DEPTH);
		end else begin
			n_eff = NW'(count_q);
		end
	end

	always_comb begin
		launch_pkt   = '0;
		launch_pkt.q = item.data.query_lambda;
	end

	assign chain_vld[0] = launch;
	assign chain_pkt[0] = launch_pkt;

	// chain of table cells
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		tli_cell #(.IDX(i), .NW(NW)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.wr_en     (load_en),
			.wr_index  (item.data.point_index),
			.wr_lambda (item.data.point_lambda),
			.wr_flux   (item.data.point_flux),
			.n_eff     (n_eff),
			.vld_in    (chain_vld[i]),
			.pkt_in    (chain_pkt[i]),
			.vld_out   (chain_vld[i+1]),
			.pkt_out   (chain_pkt[i+1])
		);
	end

	assign tail = chain_pkt[TABLE_DEPTH];
	assign d    = {tail.f1[31], tail.f1} - {tail.f0[31], tail.f0};

	// widen product with the top bit of the magnitude
	assign dvd = {1'b0, prod_s1} + (mag_q[32] ? {1'b0, t_q, 32'b0} : 65'd0);

	assign trial = {rem_q, quo_q[32]};
	assign ge    = trial >= {1'b0, span_q};

	assign fin_flux = neg_q ? (f0_q - quo_q[31:0]) : (f0_q + quo_q[31:0]);
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || result.ready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (launch) state_q <= ST_SRCH;
				ST_SRCH: begin
					if (chain_vld[TABLE_DEPTH]) begin
						if ((tail.q < tail.first_l) || (tail.q >= tail.last_l)) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL:  state_q <= ST_ADD;
				ST_ADD:  state_q <= ST_DIV;
				ST_DIV:  if (cnt_q == 6'(DIV_STEPS - 1)) state_q <= ST_DONE;
				ST_DONE: if (out_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath: clamp decision, multiply, restoring divide
	always_ff @(posedge clk) begin
		case (state_q)
			ST_SRCH: begin
				if (chain_vld[TABLE_DEPTH]) begin
					lo_q     <= 1'b0;
					hi_q     <= 1'b0;
					interp_q <= 1'b0;
					if (tail.q < tail.first_l) begin
						res_flux_q <= tail.first_f;
						lo_q       <= 1'b1;
					end else if (tail.q >= tail.last_l) begin
						res_flux_q <= tail.last_f;
						hi_q       <= 1'b1;
					end else begin
						interp_q <= 1'b1;
					end
					f0_q   <= tail.f0;
					neg_q  <= d[32];
					mag_q  <= d[32] ? (33'd0 - d) : d;
					t_q    <= tail.q - tail.l0;
					span_q <= tail.l1 - tail.l0;
				end
			end
			ST_MUL: prod_s1 <= 64'(mag_q[31:0]) * 64'(t_q);
			ST_ADD: begin
				rem_q <= dvd[64:33];
				quo_q <= dvd[32:0];
				cnt_q <= '0;
			end
			ST_DIV: begin
				rem_q <= ge ? 32'(trial - {1'b0, span_q}) : trial[31:0];
				quo_q <= {quo_q[31:0], ge};
				cnt_q <= cnt_q + 6'd1;
			end
			default: ;
		endcase
	end

	// output register: hold the word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.flux_value   <= interp_q ? fin_flux : res_flux_q;
			out_q.clamped_low  <= lo_q;
			out_q.clamped_high <= hi_q;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	// at most one query travels the chain
	a_one_in_chain: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(chain_vld)) else $error("more than one query in chain");

	// the chain only delivers while the sequencer waits for it
	a_tail_in_srch: assert property (@(posedge clk) disable iff (!arst_n)
		chain_vld[TABLE_DEPTH] |-> (state_q == ST_SRCH))
		else $error("chain output outside search");

	// divider remainder stays below the divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < span_q)) else $error("remainder overflow");

	// flags are exclusive on every delivered word
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.clamped_low && out_q.clamped_high))
		else $error("both clamp flags set");

endmodule
